// ===== design/lsol_pkg.sv =====
// Shared types and constants for the leap second offset lookup.
// Used by every module of the block but lsol_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lsol_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int JD_W    = 40;
  localparam int MJD_W   = 36;
  localparam int BASE_W  = 32;
  localparam int RATE_W  = 32;
  localparam int OUT_W   = 40;
  localparam int SLOT_W  = 6;
  localparam int COUNT_W = 7;
  localparam int SUM_W   = 42;

  // 2400000.5 days with 16 fraction bits
  localparam logic [JD_W-1:0] JD_OFFSET_FX = 40'd157286432768;

  localparam logic signed [SUM_W-1:0] SUM_MAX = 42'sd549755813887;
  localparam logic signed [SUM_W-1:0] SUM_MIN = -42'sd549755813888;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    REGION_BEFORE = 2'd0,
    REGION_INSIDE = 2'd1,
    REGION_PAST   = 2'd2,
    REGION_LOAD   = 2'd3
  } region_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK_FIRST,
    ST_CHK_LAST,
    ST_PROBE,
    ST_CMP,
    ST_FETCH,
    ST_LAUNCH,
    ST_EVAL
  } state_t;

  typedef struct packed {
    logic [JD_W-1:0]   start_jd;
    logic [BASE_W-1:0] base_offset;
    logic [MJD_W-1:0]  ref_mjd;
    logic [RATE_W-1:0] drift_rate;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  addr;
    entry_t            data;
  } ram_wr_t;

  typedef struct packed {
    logic              valid;
    logic [MJD_W-1:0]  mjd;
    logic [MJD_W-1:0]  ref_mjd;
    logic [BASE_W-1:0] base_offset;
    logic [RATE_W-1:0] drift_rate;
  } eval_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [OUT_W-1:0] value;
    logic                    sat;
  } eval_rsp_t;

  typedef struct packed {
    logic                    valid;
    logic signed [OUT_W-1:0] value;
    region_t                 region;
    logic [SLOT_W-1:0]       used;
    logic                    sat;
  } result_t;

endpackage

`default_nettype wire

// ===== design/lsol_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Stand-alone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module lsol_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/lsol_seg_eval.sv =====
// Segment formula unit: base + rate * (mjd - ref), rounded and clamped.
// Five register steps, one in flight. Depends on lsol_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsol_seg_eval
  import lsol_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire eval_req_t req,
  output eval_rsp_t      rsp
);

  logic [4:0]              v_r;
  logic [MJD_W:0]          diff_r;
  logic [BASE_W-1:0]       base_r;
  logic [RATE_W-1:0]       rate_r;
  logic                    neg_r;
  logic [MJD_W-1:0]        mag_r;
  logic [63:0]             plo_r;
  logic [35:0]             phi_r;
  logic [36:0]             q_r;
  logic signed [OUT_W-1:0] value_r;
  logic                    sat_r;

  logic [MJD_W:0]          diff_nxt;
  logic [MJD_W-1:0]        mag_nxt;
  logic [36:0]             q_nxt;
  logic signed [SUM_W-1:0] term_s;
  logic signed [SUM_W-1:0] sum_s;

  always_comb begin
    diff_nxt = {1'b0, req.mjd} - {1'b0, req.ref_mjd};
    mag_nxt  = diff_r[MJD_W] ? MJD_W'(-diff_r) : diff_r[MJD_W-1:0];
    // round to nearest on the magnitude: carry in bit 31 of the low product
    q_nxt    = 37'(phi_r) + 37'(plo_r[63:32]) + 37'(plo_r[31]);
    term_s   = neg_r ? -$signed({5'b0, q_r}) : $signed({5'b0, q_r});
    sum_s    = $signed({10'b0, base_r}) + term_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[3:0], req.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid) begin
      diff_r <= diff_nxt;
      base_r <= req.base_offset;
      rate_r <= req.drift_rate;
    end
    neg_r <= diff_r[MJD_W];
    mag_r <= mag_nxt;
    plo_r <= rate_r * mag_r[31:0];
    phi_r <= rate_r * mag_r[MJD_W-1:32];
    q_r   <= q_nxt;
    if (sum_s > SUM_MAX) begin
      value_r <= OUT_W'(SUM_MAX);
      sat_r   <= 1'b1;
    end else if (sum_s < SUM_MIN) begin
      value_r <= OUT_W'(SUM_MIN);
      sat_r   <= 1'b1;
    end else begin
      value_r <= OUT_W'(sum_s);
      sat_r   <= 1'b0;
    end
  end

  assign rsp.done  = v_r[4];
  assign rsp.value = value_r;
  assign rsp.sat   = sat_r;

endmodule

`default_nettype wire

// ===== design/lsol_ctrl.sv =====
// Sequencer: loads, bound checks and the binary search over start dates
// through one comparator and the table read port. Depends on lsol_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsol_ctrl
  import lsol_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire logic               in_operation,
  input  wire logic [SLOT_W-1:0]  in_entry_slot,
  input  wire logic [JD_W-1:0]    in_entry_start_jd,
  input  wire logic [BASE_W-1:0]  in_entry_base_offset,
  input  wire logic [MJD_W-1:0]   in_entry_ref_mjd,
  input  wire logic [RATE_W-1:0]  in_entry_drift_rate,
  input  wire logic [MJD_W-1:0]   in_query_mjd,
  input  wire logic [COUNT_W-1:0] entry_count,
  input  wire entry_t             rd_data,
  input  wire eval_rsp_t          rsp,
  output logic                    busy,
  output ram_wr_t                 wr,
  output logic [IDX_W-1:0]        rd_addr,
  output eval_req_t               req,
  output result_t                 res
);

  state_t            state_r, state_nxt;
  logic [MJD_W-1:0]  mjd_r, mjd_nxt;
  logic [JD_W-1:0]   jd_r, jd_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  first_r, first_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  region_t           region_r, region_nxt;

  logic [CNT_W-1:0]  n_calc;
  logic [CNT_W-1:0]  step;
  logic [CNT_W-1:0]  at;
  logic [CNT_W-1:0]  last;
  logic [CNT_W-1:0]  fidx;
  logic              jd_lt;
  logic              jd_gt;
  logic [CNT_W-1:0]  cmp_first;
  logic [CNT_W-1:0]  cmp_cnt;
  logic              is_query;

  always_comb begin
    if (entry_count == '0) begin
      n_calc = CNT_W'(1);
    end else if (32'(entry_count) > TABLE_DEPTH) begin
      n_calc = CNT_W'(TABLE_DEPTH);
    end else begin
      n_calc = CNT_W'(entry_count);
    end
    step  = cnt_r >> 1;
    at    = first_r + step;
    last  = n_r - CNT_W'(1);
    fidx  = (first_r == '0) ? '0 : first_r - CNT_W'(1);
    // the one shared comparator
    jd_lt = jd_r < rd_data.start_jd;
    jd_gt = jd_r > rd_data.start_jd;
    if (!jd_lt) begin
      cmp_first = at + CNT_W'(1);
      cmp_cnt   = cnt_r - step - CNT_W'(1);
    end else begin
      cmp_first = first_r;
      cmp_cnt   = step;
    end
    is_query = accept && (in_operation == OP_QUERY);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (is_query) state_nxt = ST_CHK_FIRST;
      ST_CHK_FIRST: state_nxt = jd_lt ? ST_IDLE : ST_CHK_LAST;
      ST_CHK_LAST:  state_nxt = jd_gt ? ST_EVAL : ST_PROBE;
      ST_PROBE:     state_nxt = ST_CMP;
      ST_CMP:       state_nxt = (cmp_cnt == '0) ? ST_FETCH : ST_PROBE;
      ST_FETCH:     state_nxt = ST_LAUNCH;
      ST_LAUNCH:    state_nxt = ST_EVAL;
      ST_EVAL:      if (rsp.done) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // datapath registers
  always_comb begin
    mjd_nxt    = mjd_r;
    jd_nxt     = jd_r;
    n_nxt      = n_r;
    first_nxt  = first_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    region_nxt = region_r;
    unique case (state_r)
      ST_IDLE: begin
        mjd_nxt = in_query_mjd;
        jd_nxt  = {{(JD_W-MJD_W){1'b0}}, in_query_mjd} + JD_OFFSET_FX;
        n_nxt   = n_calc;
      end
      ST_CHK_LAST: begin
        first_nxt  = '0;
        cnt_nxt    = n_r;
        idx_nxt    = last[IDX_W-1:0];
        region_nxt = jd_gt ? REGION_PAST : REGION_INSIDE;
      end
      ST_CMP: begin
        first_nxt = cmp_first;
        cnt_nxt   = cmp_cnt;
      end
      ST_FETCH: idx_nxt = fidx[IDX_W-1:0];
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    busy      = (state_r != ST_IDLE);
    wr.we     = accept && (in_operation == OP_LOAD) && (32'(in_entry_slot) < TABLE_DEPTH);
    wr.addr   = IDX_W'(in_entry_slot);
    wr.data   = '{start_jd: in_entry_start_jd, base_offset: in_entry_base_offset,
                  ref_mjd: in_entry_ref_mjd, drift_rate: in_entry_drift_rate};
    rd_addr   = '0;
    req.valid = 1'b0;
    req.mjd         = mjd_r;
    req.ref_mjd     = rd_data.ref_mjd;
    req.base_offset = rd_data.base_offset;
    req.drift_rate  = rd_data.drift_rate;
    res.valid  = 1'b0;
    res.value  = '0;
    res.region = REGION_BEFORE;
    res.used   = '0;
    res.sat    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_operation == OP_LOAD)) begin
          res.valid  = 1'b1;
          res.region = REGION_LOAD;
          res.used   = in_entry_slot;
        end
      end
      ST_CHK_FIRST: begin
        rd_addr   = last[IDX_W-1:0];
        res.valid = jd_lt;
      end
      ST_CHK_LAST: req.valid = jd_gt;
      ST_PROBE:    rd_addr = at[IDX_W-1:0];
      ST_CMP:      ;
      ST_FETCH:    rd_addr = fidx[IDX_W-1:0];
      ST_LAUNCH:   req.valid = 1'b1;
      ST_EVAL: begin
        res.valid  = rsp.done;
        res.value  = rsp.value;
        res.region = region_r;
        res.used   = SLOT_W'(idx_r);
        res.sat    = rsp.sat;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mjd_r    <= mjd_nxt;
    jd_r     <= jd_nxt;
    n_r      <= n_nxt;
    first_r  <= first_nxt;
    cnt_r    <= cnt_nxt;
    idx_r    <= idx_nxt;
    region_r <= region_nxt;
  end

endmodule

`default_nettype wire

// ===== design/leap_second_offset_lookup.sv =====
// Top level of the TAI-UTC leap second offset lookup.
// Depends on lsol_pkg, lsol_ram, lsol_seg_eval and lsol_ctrl.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//  - Input: a transaction is taken at a rising edge with start high and busy
//    low. in_operation selects a table load (writes one segment at
//    in_entry_slot) or a query (in_query_mjd).
//  - Output: each transaction yields one result, held on the out_ ports for
//    exactly one cycle while out_valid is high. The receiver cannot stall;
//    results must be taken when strobed.
//  - Config: cfg_entry_count (number of sorted valid segments) is written
//    when cfg_valid and cfg_ready are high; cfg_ready is always high. Write
//    it only while no transaction is in flight.
//  - Sequencing: a load keeps busy low and strobes its acknowledge in
//    the cycle after acceptance. A query before the first start date
//    answers from the first bound check. A query past the last entry
//    answers after the second bound check and the multiply-add unit.
//    A query inside the table runs S binary search steps (ceil(log2(n+1)),
//    at most 7 for 64 entries), each one table read and one start date
//    compare on the single comparator, then feeds its segment to the multiply-add unit.
//  - One query at a time: busy stays high until its result is strobed.
//  - Reset (rst_n low, synchronous) sets the entry count to 1 and returns
//    the sequencer to idle. Table contents are not cleared; a segment must
//    be loaded before a query may land on it.
module leap_second_offset_lookup
  import lsol_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // command channel
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic                    in_operation,
  input  wire logic [SLOT_W-1:0]       in_entry_slot,
  input  wire logic [JD_W-1:0]         in_entry_start_jd,
  input  wire logic [BASE_W-1:0]       in_entry_base_offset,
  input  wire logic [MJD_W-1:0]        in_entry_ref_mjd,
  input  wire logic [RATE_W-1:0]       in_entry_drift_rate,
  input  wire logic [MJD_W-1:0]        in_query_mjd,
  // result strobe
  output logic                         out_valid,
  output logic signed [OUT_W-1:0]      out_tai_minus_utc,
  output logic [1:0]                   out_region,
  output logic [SLOT_W-1:0]            out_entry_used,
  output logic                         out_saturated,
  // configuration write
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [COUNT_W-1:0]      cfg_entry_count
);

  logic [COUNT_W-1:0] entry_count_r;
  logic               accept;
  ram_wr_t            wr;
  logic [IDX_W-1:0]   rd_addr;
  logic [ENTRY_W-1:0] rd_raw;
  entry_t             rd_data;
  eval_req_t          req;
  eval_rsp_t          rsp;
  result_t            res;

  logic                    out_valid_r;
  logic signed [OUT_W-1:0] out_value_r;
  region_t                 out_region_r;
  logic [SLOT_W-1:0]       out_used_r;
  logic                    out_sat_r;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign rd_data   = entry_t'(rd_raw);

  // entry count register; reset value is one segment
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= COUNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      entry_count_r <= cfg_entry_count;
    end
  end

  // segment table: start date, base, reference date and rate per entry
  lsol_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (rd_addr),
    .rdata (rd_raw)
  );

  lsol_ctrl u_ctrl (
    .clk                  (clk),
    .rst_n                (rst_n),
    .accept               (accept),
    .in_operation         (in_operation),
    .in_entry_slot        (in_entry_slot),
    .in_entry_start_jd    (in_entry_start_jd),
    .in_entry_base_offset (in_entry_base_offset),
    .in_entry_ref_mjd     (in_entry_ref_mjd),
    .in_entry_drift_rate  (in_entry_drift_rate),
    .in_query_mjd         (in_query_mjd),
    .entry_count          (entry_count_r),
    .rd_data              (rd_data),
    .rsp                  (rsp),
    .busy                 (busy),
    .wr                   (wr),
    .rd_addr              (rd_addr),
    .req                  (req),
    .res                  (res)
  );

  lsol_seg_eval u_eval (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // result register: one-cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_value_r  <= res.value;
      out_region_r <= res.region;
      out_used_r   <= res.used;
      out_sat_r    <= res.sat;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_tai_minus_utc = out_value_r;
  assign out_region        = out_region_r;
  assign out_entry_used    = out_used_r;
  assign out_saturated     = out_sat_r;

endmodule

`default_nettype wire
